FILE: sv/i2cm_pkg.sv
`timescale 1ns / 1ps
// Package: shared types and constants of the I2C register access master.
package i2cm_pkg;

   // Codes of the item kind field.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_BEGIN = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Operation after classification by the front.
   typedef enum logic [1:0] {
      OP_TICK,
      OP_BEGIN,
      OP_DATA,
      OP_NONE
   } op_type;

   // Sequencer phases.
   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_START    = 5'd1,
      PH_TX_DEV   = 5'd2,
      PH_ACK_DEV  = 5'd3,
      PH_TX_REGH  = 5'd4,
      PH_ACK_REGH = 5'd5,
      PH_TX_REGL  = 5'd6,
      PH_ACK_REGL = 5'd7,
      PH_WAIT     = 5'd8,
      PH_TX_DATA  = 5'd9,
      PH_ACK_DATA = 5'd10,
      PH_RSTART   = 5'd11,
      PH_TX_DEVR  = 5'd12,
      PH_ACK_DEVR = 5'd13,
      PH_RX       = 5'd14,
      PH_MACK     = 5'd15,
      PH_STOP     = 5'd16
   } phase_type;

   // A classified item as it waits in the queue.
   typedef struct packed {
      op_type      op;
      logic        sda_sample;
      logic [7:0]  dev_address;
      logic [15:0] reg_address;
      logic        two_byte_reg;
      logic        is_read;
      logic [7:0]  byte_count;
      logic [7:0]  write_byte;
   } cmd_type;

endpackage

FILE: sv/i2cm_ifs.sv
`timescale 1ns / 1ps
// Interfaces: request and response channels of the I2C register access master.
interface i2cm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        sda_sample;
   logic [7:0]  dev_address;
   logic [15:0] reg_address;
   logic        two_byte_reg;
   logic        is_read;
   logic [7:0]  byte_count;
   logic [7:0]  write_byte;

   modport source (
      output valid, kind, sda_sample, dev_address, reg_address, two_byte_reg,
             is_read, byte_count, write_byte,
      input  ready
   );
   modport sink (
      input  valid, kind, sda_sample, dev_address, reg_address, two_byte_reg,
             is_read, byte_count, write_byte,
      output ready
   );
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl;
   logic       sda_level;
   logic       sda_drive;
   logic [7:0] read_byte;
   logic       read_valid;
   logic       read_last;
   logic       ack_valid;
   logic       ack_ok;
   logic       nack_seen;
   logic       wants_data;
   logic       busy_res;
   logic       done_res;

   modport source (
      output valid, scl, sda_level, sda_drive, read_byte, read_valid, read_last,
             ack_valid, ack_ok, nack_seen, wants_data, busy_res, done_res,
      input  ready
   );
   modport sink (
      input  valid, scl, sda_level, sda_drive, read_byte, read_valid, read_last,
             ack_valid, ack_ok, nack_seen, wants_data, busy_res, done_res,
      output ready
   );
endinterface

FILE: sv/i2cm_front.sv
`timescale 1ns / 1ps
// Front: accepts request items and classifies them for the queue.
module i2cm_front (
   i2cm_req_if.sink            req_bus,
   input  logic                q_full,
   output logic                push,
   output i2cm_pkg::cmd_type   push_cmd
);

   i2cm_pkg::op_type op;

   always_comb begin
      case (req_bus.kind)
         i2cm_pkg::KIND_TICK:  op = i2cm_pkg::OP_TICK;
         i2cm_pkg::KIND_BEGIN: op = i2cm_pkg::OP_BEGIN;
         i2cm_pkg::KIND_DATA:  op = i2cm_pkg::OP_DATA;
         default:              op = i2cm_pkg::OP_NONE;
      endcase
   end

   assign req_bus.ready = !q_full;
   assign push          = req_bus.valid && !q_full;

   always_comb begin
      push_cmd.op           = op;
      push_cmd.sda_sample   = req_bus.sda_sample;
      push_cmd.dev_address  = req_bus.dev_address;
      push_cmd.reg_address  = req_bus.reg_address;
      push_cmd.two_byte_reg = req_bus.two_byte_reg;
      push_cmd.is_read      = req_bus.is_read;
      push_cmd.write_byte   = req_bus.write_byte;
      // A read always moves at least one byte.
      if (req_bus.is_read && (req_bus.byte_count == 8'd0)) begin
         push_cmd.byte_count = 8'd1;
      end else begin
         push_cmd.byte_count = req_bus.byte_count;
      end
   end

endmodule

FILE: sv/i2cm_queue.sv
`timescale 1ns / 1ps
// Queue: short FIFO of classified items between the front and the back.
module i2cm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  i2cm_pkg::cmd_type   push_cmd,
   output logic                q_full,
   output logic                q_valid,
   output i2cm_pkg::cmd_type   q_cmd,
   input  logic                pop
);

   i2cm_pkg::cmd_type                   entry_ff [i2cm_pkg::QUEUE_DEPTH];
   logic [i2cm_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [i2cm_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [i2cm_pkg::QCNT_W-1:0]         count_ff, count_in;

   localparam logic [i2cm_pkg::QPTR_W-1:0] LAST_PTR =
      i2cm_pkg::QPTR_W'(i2cm_pkg::QUEUE_DEPTH - 1);
   localparam logic [i2cm_pkg::QCNT_W-1:0] FULL_CNT =
      i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH);

   assign q_full  = (count_ff == FULL_CNT);
   assign q_valid = (count_ff != '0);
   assign q_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: sv/i2cm_back.sv
`timescale 1ns / 1ps
// Back: waveform sequencer and registered response stage.
module i2cm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  i2cm_pkg::cmd_type   q_cmd,
   output logic                q_pop,
   i2cm_rsp_if.source          rsp_bus
);

   i2cm_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  slot_ff, slot_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  dev_ff, dev_in;
   logic [15:0] reg_ff, reg_in;
   logic        rd_ff, rd_in;
   logic        two_ff, two_in;
   logic        nack_ff, nack_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        drv_ff, drv_in;

   logic        is_tick;
   logic [7:0]  left_dec;
   logic        t_scl, t_sda, t_drv;
   logic        ev_read, ev_last, ev_ack, ev_ack_ok, ev_done;
   logic [7:0]  ev_byte;

   // Response register.
   logic        rv_ff, rv_in;
   logic        r_scl_ff, r_sda_ff, r_drv_ff;
   logic [7:0]  r_byte_ff;
   logic        r_read_ff, r_last_ff, r_ack_ff, r_ack_ok_ff;
   logic        r_nack_ff, r_wants_ff, r_busy_ff, r_done_ff;

   assign q_pop    = q_valid && (!rv_ff || rsp_bus.ready);
   assign is_tick  = (q_cmd.op == i2cm_pkg::OP_TICK);
   assign left_dec = (left_ff != 8'd0) ? left_ff - 8'd1 : 8'd0;

   // Next state of the sequencer.
   always_comb begin
      phase_in = phase_ff;
      slot_in  = slot_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      dev_in   = dev_ff;
      reg_in   = reg_ff;
      rd_in    = rd_ff;
      two_in   = two_ff;
      nack_in  = nack_ff;
      if (q_pop) begin
         case (q_cmd.op)
            i2cm_pkg::OP_TICK: begin
               case (phase_ff)
                  i2cm_pkg::PH_START, i2cm_pkg::PH_RSTART: begin
                     if (slot_ff == 2'd2) begin
                        slot_in = 2'd0;
                        bit_in  = 3'd0;
                        if (phase_ff == i2cm_pkg::PH_START) begin
                           phase_in = i2cm_pkg::PH_TX_DEV;
                           shift_in = dev_ff;
                        end else begin
                           phase_in = i2cm_pkg::PH_TX_DEVR;
                           shift_in = dev_ff + 8'd1;
                        end
                     end else begin
                        slot_in = slot_ff + 2'd1;
                     end
                  end
                  i2cm_pkg::PH_TX_DEV, i2cm_pkg::PH_TX_REGH, i2cm_pkg::PH_TX_REGL,
                  i2cm_pkg::PH_TX_DATA, i2cm_pkg::PH_TX_DEVR: begin
                     if (slot_ff == 2'd2) begin
                        shift_in = {shift_ff[6:0], 1'b0};
                        slot_in  = 2'd0;
                        if (bit_ff == 3'd7) begin
                           bit_in = 3'd0;
                           case (phase_ff)
                              i2cm_pkg::PH_TX_DEV:  phase_in = i2cm_pkg::PH_ACK_DEV;
                              i2cm_pkg::PH_TX_REGH: phase_in = i2cm_pkg::PH_ACK_REGH;
                              i2cm_pkg::PH_TX_REGL: phase_in = i2cm_pkg::PH_ACK_REGL;
                              i2cm_pkg::PH_TX_DATA: phase_in = i2cm_pkg::PH_ACK_DATA;
                              default:              phase_in = i2cm_pkg::PH_ACK_DEVR;
                           endcase
                        end else begin
                           bit_in = bit_ff + 3'd1;
                        end
                     end else begin
                        slot_in = slot_ff + 2'd1;
                     end
                  end
                  i2cm_pkg::PH_ACK_DEV, i2cm_pkg::PH_ACK_REGH, i2cm_pkg::PH_ACK_REGL,
                  i2cm_pkg::PH_ACK_DATA, i2cm_pkg::PH_ACK_DEVR: begin
                     if ((slot_ff == 2'd1) && q_cmd.sda_sample) begin
                        nack_in = 1'b1;
                     end
                     if (slot_ff == 2'd2) begin
                        slot_in = 2'd0;
                        bit_in  = 3'd0;
                        case (phase_ff)
                           i2cm_pkg::PH_ACK_DEV: begin
                              if (two_ff) begin
                                 phase_in = i2cm_pkg::PH_TX_REGH;
                                 shift_in = reg_ff[15:8];
                              end else begin
                                 phase_in = i2cm_pkg::PH_TX_REGL;
                                 shift_in = reg_ff[7:0];
                              end
                           end
                           i2cm_pkg::PH_ACK_REGH: begin
                              phase_in = i2cm_pkg::PH_TX_REGL;
                              shift_in = reg_ff[7:0];
                           end
                           i2cm_pkg::PH_ACK_REGL, i2cm_pkg::PH_ACK_DATA: begin
                              bit_in = bit_ff;
                              if ((phase_ff == i2cm_pkg::PH_ACK_REGL) && rd_ff) begin
                                 phase_in = i2cm_pkg::PH_RSTART;
                              end else if (left_ff != 8'd0) begin
                                 phase_in = i2cm_pkg::PH_WAIT;
                              end else begin
                                 phase_in = i2cm_pkg::PH_STOP;
                              end
                           end
                           default: begin
                              phase_in = i2cm_pkg::PH_RX;
                              shift_in = 8'd0;
                           end
                        endcase
                     end else begin
                        slot_in = slot_ff + 2'd1;
                     end
                  end
                  i2cm_pkg::PH_RX: begin
                     if (slot_ff == 2'd0) begin
                        shift_in = {shift_ff[6:0], q_cmd.sda_sample};
                        slot_in  = 2'd1;
                     end else begin
                        slot_in = 2'd0;
                        if (bit_ff == 3'd7) begin
                           bit_in   = 3'd0;
                           phase_in = i2cm_pkg::PH_MACK;
                        end else begin
                           bit_in = bit_ff + 3'd1;
                        end
                     end
                  end
                  i2cm_pkg::PH_MACK: begin
                     if (slot_ff == 2'd2) begin
                        left_in = left_dec;
                        slot_in = 2'd0;
                        if (left_dec == 8'd0) begin
                           phase_in = i2cm_pkg::PH_STOP;
                        end else begin
                           phase_in = i2cm_pkg::PH_RX;
                           shift_in = 8'd0;
                           bit_in   = 3'd0;
                        end
                     end else begin
                        slot_in = slot_ff + 2'd1;
                     end
                  end
                  i2cm_pkg::PH_STOP: begin
                     if (slot_ff == 2'd2) begin
                        phase_in = i2cm_pkg::PH_IDLE;
                        slot_in  = 2'd0;
                     end else begin
                        slot_in = slot_ff + 2'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            i2cm_pkg::OP_BEGIN: begin
               if (phase_ff == i2cm_pkg::PH_IDLE) begin
                  dev_in   = q_cmd.dev_address;
                  reg_in   = q_cmd.reg_address;
                  rd_in    = q_cmd.is_read;
                  two_in   = q_cmd.two_byte_reg;
                  left_in  = q_cmd.byte_count;
                  nack_in  = 1'b0;
                  shift_in = 8'd0;
                  bit_in   = 3'd0;
                  slot_in  = 2'd0;
                  phase_in = i2cm_pkg::PH_START;
               end
            end
            i2cm_pkg::OP_DATA: begin
               if (phase_ff == i2cm_pkg::PH_WAIT) begin
                  phase_in = i2cm_pkg::PH_TX_DATA;
                  shift_in = q_cmd.write_byte;
                  bit_in   = 3'd0;
                  slot_in  = 2'd0;
                  left_in  = left_dec;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Pin levels and events of the slot that a tick plays out.
   always_comb begin
      t_scl     = scl_ff;
      t_sda     = sda_ff;
      t_drv     = drv_ff;
      ev_read   = 1'b0;
      ev_last   = 1'b0;
      ev_byte   = 8'd0;
      ev_ack    = 1'b0;
      ev_ack_ok = 1'b0;
      ev_done   = 1'b0;
      case (phase_ff)
         i2cm_pkg::PH_START, i2cm_pkg::PH_RSTART: begin
            t_scl = (slot_ff < 2'd2);
            t_sda = (slot_ff == 2'd0);
            t_drv = 1'b1;
         end
         i2cm_pkg::PH_TX_DEV, i2cm_pkg::PH_TX_REGH, i2cm_pkg::PH_TX_REGL,
         i2cm_pkg::PH_TX_DATA, i2cm_pkg::PH_TX_DEVR: begin
            t_scl = (slot_ff == 2'd1);
            t_sda = shift_ff[7];
            t_drv = 1'b1;
         end
         i2cm_pkg::PH_ACK_DEV, i2cm_pkg::PH_ACK_REGH, i2cm_pkg::PH_ACK_REGL,
         i2cm_pkg::PH_ACK_DATA, i2cm_pkg::PH_ACK_DEVR: begin
            t_sda = 1'b1;
            if (slot_ff == 2'd2) begin
               // The last ack slot leaves SCL low and takes SDA back.
               t_scl = 1'b0;
               t_drv = 1'b1;
            end else begin
               t_scl = (slot_ff == 2'd1);
               t_drv = 1'b0;
            end
            if (slot_ff == 2'd1) begin
               ev_ack    = 1'b1;
               ev_ack_ok = !q_cmd.sda_sample;
            end
         end
         i2cm_pkg::PH_RX: begin
            t_scl = (slot_ff == 2'd0);
            t_sda = 1'b1;
            t_drv = 1'b0;
            if ((slot_ff == 2'd0) && (bit_ff == 3'd7)) begin
               ev_read = 1'b1;
               ev_byte = {shift_ff[6:0], q_cmd.sda_sample};
               ev_last = (left_ff == 8'd1);
            end
         end
         i2cm_pkg::PH_MACK: begin
            t_scl = (slot_ff == 2'd1);
            t_sda = (left_ff <= 8'd1);
            t_drv = 1'b1;
         end
         i2cm_pkg::PH_STOP: begin
            t_scl   = (slot_ff >= 2'd1);
            t_sda   = (slot_ff == 2'd2);
            t_drv   = 1'b1;
            ev_done = (slot_ff == 2'd2);
         end
         default: begin
         end
      endcase
   end

   assign scl_in = (q_pop && is_tick) ? t_scl : scl_ff;
   assign sda_in = (q_pop && is_tick) ? t_sda : sda_ff;
   assign drv_in = (q_pop && is_tick) ? t_drv : drv_ff;
   assign rv_in  = q_pop || (rv_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cm_pkg::PH_IDLE;
         slot_ff  <= 2'd0;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         left_ff  <= 8'd0;
         dev_ff   <= 8'd0;
         reg_ff   <= 16'd0;
         rd_ff    <= 1'b0;
         two_ff   <= 1'b0;
         nack_ff  <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         drv_ff   <= 1'b1;
         rv_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
         dev_ff   <= dev_in;
         reg_ff   <= reg_in;
         rd_ff    <= rd_in;
         two_ff   <= two_in;
         nack_ff  <= nack_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         drv_ff   <= drv_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         r_scl_ff    <= scl_in;
         r_sda_ff    <= sda_in;
         r_drv_ff    <= drv_in;
         r_byte_ff   <= is_tick ? ev_byte : 8'd0;
         r_read_ff   <= is_tick && ev_read;
         r_last_ff   <= is_tick && ev_last;
         r_ack_ff    <= is_tick && ev_ack;
         r_ack_ok_ff <= is_tick && ev_ack_ok;
         r_done_ff   <= is_tick && ev_done;
         r_nack_ff   <= nack_in;
         r_wants_ff  <= (phase_in == i2cm_pkg::PH_WAIT);
         r_busy_ff   <= (phase_in != i2cm_pkg::PH_IDLE);
      end
   end

   assign rsp_bus.valid      = rv_ff;
   assign rsp_bus.scl        = r_scl_ff;
   assign rsp_bus.sda_level  = r_sda_ff;
   assign rsp_bus.sda_drive  = r_drv_ff;
   assign rsp_bus.read_byte  = r_byte_ff;
   assign rsp_bus.read_valid = r_read_ff;
   assign rsp_bus.read_last  = r_last_ff;
   assign rsp_bus.ack_valid  = r_ack_ff;
   assign rsp_bus.ack_ok     = r_ack_ok_ff;
   assign rsp_bus.nack_seen  = r_nack_ff;
   assign rsp_bus.wants_data = r_wants_ff;
   assign rsp_bus.busy_res   = r_busy_ff;
   assign rsp_bus.done_res   = r_done_ff;

   // A finished stop leaves the bus idle with both lines high.
   ap_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.done_res) |->
         (!rsp_bus.busy_res && rsp_bus.scl && rsp_bus.sda_level))
      else $error("stop finished but bus not idle");

   // Slave ack and received bits are sampled with SCL high and SDA released.
   ap_sample_released: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.ack_valid || rsp_bus.read_valid)) |->
         (rsp_bus.scl && !rsp_bus.sda_drive))
      else $error("sample taken while SDA driven or SCL low");

   // A receive bit has only two slots.
   ap_rx_slot: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == i2cm_pkg::PH_RX) |-> !slot_ff[1])
      else $error("receive bit slot out of range");

   // Idle leaves the slot and bit counters cleared.
   ap_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == i2cm_pkg::PH_IDLE) |-> ((slot_ff == 2'd0) && (bit_ff == 3'd0)))
      else $error("idle with stale slot or bit counter");

   // While waiting for data the master holds SCL low and drives SDA.
   ap_wait_pins: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == i2cm_pkg::PH_WAIT) |-> (!scl_ff && drv_ff))
      else $error("wrong pin state while waiting for data");

endmodule

FILE: sv/i2c_master_register_access_top.sv
`timescale 1ns / 1ps
// A result enters the response register when the back pops its item from the queue.
// Throughput: one item per cycle while the response register is empty or being taken.
// The two-entry queue and the response register let either side stall on its own.
// Reset (synchronous, active high) empties the queue and response stage, and leaves
// the sequencer idle with SCL high and SDA high and driven.
// Top level: I2C master for register read and write transactions.
module i2c_master_register_access_top (
   input  logic        clock,
   input  logic        reset,
   i2cm_req_if.sink    req_bus,
   i2cm_rsp_if.source  rsp_bus
);

   // The front takes one item per cycle whenever the queue has room. It
   // decodes the kind field into an operation and turns a read of zero bytes
   // into a read of one byte, so the back never has to look at that case.
   logic                 push;
   logic                 q_full;
   i2cm_pkg::cmd_type    push_cmd;

   // The queue hands items to the back in order. Every item, including ticks
   // that hold the pins and items that are ignored, yields exactly one result.
   logic                 q_valid;
   logic                 q_pop;
   i2cm_pkg::cmd_type    q_cmd;

   i2cm_front u_front (
      .req_bus  (req_bus),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   i2cm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .q_full   (q_full),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .pop      (q_pop)
   );

   // The back runs the start, repeated start, address, data, ack and stop slots. Each tick
   // item advances one slot. A begin item while busy and a data item that is
   // not awaited change nothing, but still report the held pin levels. The
   // back pops the next item whenever its response register is empty or
   // being taken in the same cycle.
   i2cm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop),
      .rsp_bus  (rsp_bus)
   );

endmodule
